// ===== src/bbd_pkg.sv =====
// shared types, constants and decode functions for the byte-level byte decoder
`timescale 1ns / 1ps

package bbd_pkg;

    // lead byte classification masks
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_VAL   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_VAL   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_VAL   = 8'hF0;

    // two-byte leads that can reach the alphabet
    localparam logic [7:0] LEAD_CP_LO  = 8'hC2;
    localparam logic [7:0] LEAD_CP_HI  = 8'hC5;

    // code points that stand for themselves
    localparam logic [8:0] CP_RANGE1_LO = 9'h0A1;
    localparam logic [8:0] CP_RANGE1_HI = 9'h0AC;
    localparam logic [8:0] CP_RANGE2_LO = 9'h0AE;
    localparam logic [8:0] CP_RANGE2_HI = 9'h0FF;

    // shifted code points 256 and up
    localparam logic [8:0] CP_EXTRA_LO  = 9'd256;
    localparam logic [8:0] CP_EXTRA_END = 9'd324;

    // extra code point offsets
    localparam logic [7:0] EXTRA_LOW_END = 8'd33;
    localparam logic [7:0] EXTRA_MID_END = 8'd67;
    localparam logic [7:0] EXTRA_MID_ADD = 8'h5E;
    localparam logic [7:0] EXTRA_SOFT_HY = 8'hAD;

    localparam logic [2:0] MAX_RESULTS = 3'd4;

    // channel payloads
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } bbd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } bbd_out_t;

    typedef logic [3:0][7:0] bbd_seq_t;

    // one group of result bytes for one transaction
    typedef struct packed {
        bbd_seq_t   bytes;
        logic [2:0] count;
    } bbd_entry_t;

    // open sequence state
    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      cnt;
        logic [2:0]      slen;
    } bbd_state_t;

    typedef struct packed {
        bbd_state_t state;
        bbd_entry_t emit;
    } bbd_feed_t;

    typedef enum logic {
        FR_IDLE,
        FR_RESCAN
    } bbd_front_state_t;

    // sequence length from lead byte, zero for an invalid lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7]) begin
            len = 3'd1;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // byte that stands for code point 256 + n
    function automatic logic [7:0] extra_byte(input logic [6:0] n);
        logic [7:0] n8;
        logic [7:0] r;
        n8 = {1'b0, n};
        if (n8 < EXTRA_LOW_END) begin
            r = n8;
        end else if (n8 < EXTRA_MID_END) begin
            r = n8 + EXTRA_MID_ADD;
        end else begin
            r = EXTRA_SOFT_HY;
        end
        return r;
    endfunction

    // map a complete sequence back to bytes, raw when outside the alphabet
    function automatic bbd_entry_t emit_sequence(input bbd_seq_t seq, input logic [2:0] len);
        bbd_entry_t r;
        logic [8:0] cp;
        r.bytes = seq;
        r.count = len;
        cp      = {seq[0][2:0], seq[1][5:0]};
        if (len == 3'd2 && seq[0] >= LEAD_CP_LO && seq[0] <= LEAD_CP_HI
            && seq[1][7:6] == 2'b10) begin
            if ((cp >= CP_RANGE1_LO && cp <= CP_RANGE1_HI)
                || (cp >= CP_RANGE2_LO && cp <= CP_RANGE2_HI)) begin
                r.bytes[0] = cp[7:0];
                r.count    = 3'd1;
            end else if (cp >= CP_EXTRA_LO && cp < CP_EXTRA_END) begin
                r.bytes[0] = extra_byte(cp[6:0]);
                r.count    = 3'd1;
            end
        end
        return r;
    endfunction

    // take one byte into the open sequence state
    function automatic bbd_feed_t feed(input bbd_state_t s, input logic [7:0] b);
        bbd_feed_t  r;
        logic [2:0] len;
        bbd_seq_t   seq;
        r.state    = s;
        r.emit     = '0;
        len        = lead_length(b);
        seq[2:0]   = s.held;
        seq[3]     = 8'h00;
        seq[s.cnt] = b;
        if (s.cnt == 2'd0) begin
            if (len == 3'd1) begin
                r.emit.bytes[0] = b;
                r.emit.count    = 3'd1;
            end else if (len != 3'd0) begin
                r.state.held[0] = b;
                r.state.cnt     = 2'd1;
                r.state.slen    = len;
            end
        end else if ({1'b0, s.cnt} + 3'd1 >= s.slen || s.cnt == 2'd3) begin
            r.emit       = emit_sequence(seq, {1'b0, s.cnt} + 3'd1);
            r.state.cnt  = 2'd0;
            r.state.slen = 3'd0;
        end else begin
            r.state.held[s.cnt] = b;
            r.state.cnt         = s.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== src/bbd_front.sv =====
// front end: sequence collection, classification and end-of-text rescan
`timescale 1ns / 1ps

module bbd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bbd_pkg::bbd_in_t     s_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output bbd_pkg::bbd_entry_t  push_entry
);
    import bbd_pkg::*;

    bbd_front_state_t mode_reg, mode_next;
    bbd_state_t       st_reg, st_next;
    logic [1:0][7:0]  pend_reg, pend_next;
    logic [1:0]       pend_cnt_reg, pend_cnt_next;
    bbd_entry_t       acc_reg, acc_next;

    logic [7:0]       feed_byte;
    bbd_feed_t        fres;
    bbd_entry_t       merged;
    logic [3:0]       slot;
    logic [3:0]       sum;

    // one shared feed step, input byte or pending rescan byte
    assign feed_byte = (mode_reg == FR_IDLE) ? s_data.in_byte : pend_reg[0];
    assign fres      = feed(st_reg, feed_byte);
    assign s_ready   = (mode_reg == FR_IDLE) && push_ready;

    // append feed results to the accumulated group
    always_comb begin
        merged = acc_reg;
        slot   = 4'd0;
        for (int i = 0; i < 4; i++) begin
            slot = {1'b0, acc_reg.count} + 4'(i);
            if (3'(i) < fres.emit.count && slot < {1'b0, MAX_RESULTS}) begin
                merged.bytes[slot[1:0]] = fres.emit.bytes[i];
            end
        end
        sum = {1'b0, acc_reg.count} + {1'b0, fres.emit.count};
        merged.count = (sum > {1'b0, MAX_RESULTS}) ? MAX_RESULTS : sum[2:0];
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= FR_IDLE;
            st_reg       <= '0;
            pend_cnt_reg <= 2'd0;
            acc_reg      <= '0;
        end else begin
            mode_reg     <= mode_next;
            st_reg       <= st_next;
            pend_cnt_reg <= pend_cnt_next;
            acc_reg      <= acc_next;
        end
    end

    // pending rescan bytes
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    // next state and queue push
    always_comb begin
        mode_next     = mode_reg;
        st_next       = st_reg;
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        acc_next      = acc_reg;
        push_valid    = 1'b0;
        push_entry    = acc_reg;
        case (mode_reg)
            FR_IDLE: begin
                if (s_valid && s_ready) begin
                    st_next = fres.state;
                    if (s_data.end_of_text && fres.state.cnt != 2'd0) begin
                        mode_next     = FR_RESCAN;
                        acc_next      = fres.emit;
                        pend_next[0]  = fres.state.held[1];
                        pend_next[1]  = fres.state.held[2];
                        pend_cnt_next = fres.state.cnt - 2'd1;
                        st_next       = '0;
                    end else if (fres.emit.count != 3'd0) begin
                        push_valid = 1'b1;
                        push_entry = fres.emit;
                    end
                end
            end
            FR_RESCAN: begin
                if (pend_cnt_reg != 2'd0) begin
                    st_next       = fres.state;
                    acc_next      = merged;
                    pend_next[0]  = pend_reg[1];
                    pend_cnt_next = pend_cnt_reg - 2'd1;
                end else if (st_reg.cnt != 2'd0) begin
                    // truncated again: drop its lead, rescan the rest
                    pend_next[0]  = st_reg.held[1];
                    pend_next[1]  = st_reg.held[2];
                    pend_cnt_next = st_reg.cnt - 2'd1;
                    st_next       = '0;
                end else if (acc_reg.count == 3'd0) begin
                    mode_next = FR_IDLE;
                end else begin
                    push_valid = 1'b1;
                    push_entry = acc_reg;
                    if (push_ready) begin
                        mode_next = FR_IDLE;
                    end
                end
            end
            default: begin
                mode_next = FR_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bbd_queue.sv =====
// small queue of result groups between front and back
`timescale 1ns / 1ps

module bbd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  bbd_pkg::bbd_entry_t  push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output bbd_pkg::bbd_entry_t  pop_entry
);
    import bbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bbd_entry_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/bbd_back.sv =====
// back end: sends each queued group out one byte per transaction
`timescale 1ns / 1ps

module bbd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  bbd_pkg::bbd_entry_t  pop_entry,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bbd_pkg::bbd_out_t    m_data
);
    import bbd_pkg::*;

    logic       busy_reg, busy_next;
    bbd_entry_t ent_reg, ent_next;
    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       take;

    assign last      = ({1'b0, idx_reg} + 3'd1 == ent_reg.count);
    assign take      = m_valid && m_ready;
    assign pop_ready = !busy_reg || (take && last);

    assign m_valid         = busy_reg;
    assign m_data.out_byte = ent_reg.bytes[idx_reg];
    assign m_data.run_last = last;

    // step through the group, load the next when done
    always_comb begin
        busy_next = busy_reg;
        ent_next  = ent_reg;
        idx_next  = idx_reg;
        if (take && !last) begin
            idx_next = idx_reg + 2'd1;
        end
        if (pop_ready) begin
            busy_next = pop_valid;
            ent_next  = pop_entry;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

// ===== src/byte_level_unicode_to_byte_decoder.sv =====
// Byte-level byte decoder: takes token text one byte per transaction, collects each UTF-8
// sequence by its lead byte, maps sequences of the byte alphabet back to their raw byte
// and passes any other sequence through raw (one to four bytes); invalid leads are
// dropped, and at end of text a truncated sequence loses its lead and the rest is
// rescanned. run_last marks the last result of an input transaction; a transaction may
// give no result at all. The front accepts one byte per cycle while the result queue
// (QUEUE_DEPTH groups) has room; an end-of-text byte that leaves a sequence open holds
// the front in rescan, one feed, re-truncate or finish step per cycle, plus any wait for
// queue room for its result group. The back sends one result byte per cycle while
// m_ready is high.
`timescale 1ns / 1ps

module byte_level_unicode_to_byte_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bbd_pkg::bbd_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bbd_pkg::bbd_out_t  m_data
);
    import bbd_pkg::*;

    logic       push_valid;
    logic       push_ready;
    bbd_entry_t push_entry;
    logic       pop_valid;
    logic       pop_ready;
    bbd_entry_t pop_entry;

    // sequence collection and rescan
    bbd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // result groups waiting for the output
    bbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // byte-wise output
    bbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // every pushed group holds one to four bytes
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (push_entry.count != 3'd0 && push_entry.count <= MAX_RESULTS))
        else $error("result group with bad byte count");

    // a group is sent without gaps once started
    a_group_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.run_last) |=> m_valid)
        else $error("gap inside a result group");

    // input is only taken when the queue can take a group
    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> push_ready)
        else $error("input accepted without queue room");

    // reset empties the output
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

// ===== tb/byte_level_unicode_to_byte_decoder_tb.sv =====
// testbench for the byte-level unicode-to-byte decoder, checked against a built-in predictor
`timescale 1ns / 1ps

module byte_level_unicode_to_byte_decoder_tb;
    import bbd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 345;
    localparam int SETTLE       = 40;
    localparam int MAX_PER_STEP = 4;

    // alphabet bounds and the shifted code point block
    localparam logic [7:0]  PRINT_LO   = 8'h21;
    localparam logic [7:0]  PRINT_HI   = 8'h7E;
    localparam logic [7:0]  PAIR_LEAD_LO = 8'hC2;
    localparam logic [7:0]  PAIR_LEAD_HI = 8'hC5;
    localparam logic [10:0] LATIN_A_LO = 11'h0A1;
    localparam logic [10:0] LATIN_A_HI = 11'h0AC;
    localparam logic [10:0] LATIN_B_LO = 11'h0AE;
    localparam logic [10:0] LATIN_B_HI = 11'h0FF;
    localparam int          SHIFT_BASE = 256;
    localparam int          SHIFT_SIZE = 68;

    // one row of the directed table; typed rows carry their own expected bytes
    typedef struct packed {
        logic [7:0]      in_byte;
        logic            eot;
        logic            typed;
        logic [2:0]      count;
        logic [0:3][7:0] bytes;
    } text_row_t;

    localparam int DIRECTED_LEN = 26;
    localparam text_row_t DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
        '{8'h41, 1'b0, 1'b1, 3'd1, 32'h41000000},   // printable ascii maps to itself
        '{8'h00, 1'b0, 1'b1, 3'd1, 32'h00000000},   // control byte passes raw
        '{8'h7F, 1'b0, 1'b1, 3'd1, 32'h7F000000},
        '{8'h80, 1'b0, 1'b1, 3'd0, 32'h00000000},   // stray continuation dropped
        '{8'hFF, 1'b0, 1'b1, 3'd0, 32'h00000000},   // invalid lead dropped
        '{8'hC4, 1'b0, 1'b1, 3'd0, 32'h00000000},   // first shifted code point
        '{8'h80, 1'b0, 1'b1, 3'd1, 32'h00000000},
        '{8'hC2, 1'b0, 1'b1, 3'd0, 32'h00000000},   // lowest latin code point
        '{8'hA1, 1'b0, 1'b1, 3'd1, 32'hA1000000},
        '{8'hC5, 1'b0, 1'b1, 3'd0, 32'h00000000},   // last shifted code point
        '{8'h83, 1'b0, 1'b1, 3'd1, 32'hAD000000},
        '{8'hC3, 1'b0, 1'b1, 3'd0, 32'h00000000},   // highest latin code point
        '{8'hBF, 1'b0, 1'b1, 3'd1, 32'hFF000000},
        '{8'hC2, 1'b0, 1'b1, 3'd0, 32'h00000000},   // bad continuation passes raw
        '{8'h41, 1'b0, 1'b1, 3'd2, 32'hC2410000},
        '{8'hE2, 1'b0, 1'b1, 3'd0, 32'h00000000},   // three byte sequence outside alphabet
        '{8'h82, 1'b0, 1'b1, 3'd0, 32'h00000000},
        '{8'hAC, 1'b0, 1'b1, 3'd3, 32'hE282AC00},
        '{8'hF0, 1'b0, 1'b1, 3'd0, 32'h00000000},   // four byte sequence, most results
        '{8'h9F, 1'b0, 1'b1, 3'd0, 32'h00000000},
        '{8'h98, 1'b0, 1'b1, 3'd0, 32'h00000000},
        '{8'h80, 1'b0, 1'b1, 3'd4, 32'hF09F9880},
        '{8'hF0, 1'b0, 1'b0, 3'd0, 32'h00000000},   // truncated at end of text, rescan
        '{8'h41, 1'b0, 1'b0, 3'd0, 32'h00000000},
        '{8'hC3, 1'b1, 1'b0, 3'd0, 32'h00000000},
        '{8'hC3, 1'b1, 1'b1, 3'd0, 32'h00000000}    // lone lead at end of text
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bbd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    bbd_out_t m_data;

    // predictor state: the open sequence
    logic [2:0][7:0] open_seq;
    int              open_cnt;
    int              open_len;
    logic [7:0]      step_bytes[$];

    // decoded bytes still awaited from the block
    bbd_out_t        pending_bytes[$];

    // side info for the transaction on offer
    logic            row_typed;
    logic [2:0]      row_count;
    logic [0:3][7:0] row_bytes;

    int unsigned inputs_taken;
    int unsigned random_items;
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          calm;
    bit          hold_req;

    byte_level_unicode_to_byte_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------

    function automatic int seq_len_of(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic void keep_result(input logic [7:0] b);
        if (step_bytes.size() < MAX_PER_STEP) step_bytes.insert(step_bytes.size(), b);
    endfunction

    // byte standing for code point SHIFT_BASE + n
    function automatic logic [7:0] shifted_byte(input int unsigned n);
        logic [7:0] r;
        r = n[7:0];
        if (n >= 33 && n < 67) begin
            r = r + 8'h5E;
        end else if (n >= 67) begin
            r = 8'hAD;
        end
        return r;
    endfunction

    // complete sequence back to its byte, or raw when outside the alphabet
    function automatic void map_sequence(input logic [3:0][7:0] seq, input int len);
        logic [10:0] cp;
        int          i;
        cp = {seq[0][4:0], seq[1][5:0]};
        if (len == 1 && seq[0] >= PRINT_LO && seq[0] <= PRINT_HI) begin
            keep_result(seq[0]);
            return;
        end
        if (len == 2 && seq[0] >= PAIR_LEAD_LO && seq[0] <= PAIR_LEAD_HI
            && seq[1][7:6] == 2'b10) begin
            if ((cp >= LATIN_A_LO && cp <= LATIN_A_HI)
                || (cp >= LATIN_B_LO && cp <= LATIN_B_HI)) begin
                keep_result(cp[7:0]);
                return;
            end
            if (cp >= SHIFT_BASE && cp < SHIFT_BASE + SHIFT_SIZE) begin
                keep_result(shifted_byte(cp - SHIFT_BASE));
                return;
            end
        end
        for (i = 0; i < len; i++) keep_result(seq[i]);
    endfunction

    // one byte into the open sequence
    function automatic void take_byte(input logic [7:0] b);
        logic [3:0][7:0] seq;
        int              len;
        int              i;
        seq = '0;
        if (open_cnt == 0) begin
            len = seq_len_of(b);
            if (len == 1) begin
                seq[0] = b;
                map_sequence(seq, 1);
            end else if (len != 0) begin
                open_seq[0] = b;
                open_cnt    = 1;
                open_len    = len;
            end
        end else if (open_cnt + 1 >= open_len || open_cnt >= 3) begin
            for (i = 0; i < open_cnt; i++) seq[i] = open_seq[i];
            seq[open_cnt] = b;
            len      = open_cnt + 1;
            open_cnt = 0;
            open_len = 0;
            map_sequence(seq, len);
        end else begin
            open_seq[open_cnt] = b;
            open_cnt++;
        end
    endfunction

    // full transaction: the byte, then the end-of-text rescan
    function automatic void decode_text_byte(input logic [7:0] b, input logic eot);
        logic [2:0][7:0] rest;
        int              n;
        int              i;
        step_bytes.delete();
        take_byte(b);
        if (eot) begin
            while (open_cnt > 0) begin
                n        = open_cnt - 1;
                rest     = open_seq;
                open_cnt = 0;
                open_len = 0;
                open_seq = '0;
                for (i = 0; i < n; i++) take_byte(rest[i + 1]);
            end
        end
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input bbd_out_t want,
                                   input bbd_out_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
                     $time, what, want.out_byte, want.run_last, got.out_byte,
                     got.run_last);
        end
    endtask

    // input transactions feed the predictor, output transactions are compared
    always @(posedge aclk) begin
        int       k;
        bbd_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_text_byte(s_data.in_byte, s_data.end_of_text);
                if (row_typed) begin
                    step_bytes.delete();
                    for (k = 0; k < row_count; k++) begin
                        step_bytes.insert(step_bytes.size(), row_bytes[k]);
                    end
                end
                for (k = 0; k < step_bytes.size(); k++) begin
                    want.out_byte = step_bytes[k];
                    want.run_last = (k == step_bytes.size() - 1);
                    pending_bytes.insert(pending_bytes.size(), want);
                end
                inputs_taken++;
            end
            if (m_valid && m_ready) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_data);
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_data.out_byte !== want.out_byte
                        || m_data.run_last !== want.run_last) begin
                        report_mismatch("wrong result", want, m_data);
                    end
                end
            end
            // watchdog on cycles with no transaction on either side
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("byte_level_unicode_to_byte_decoder test failed");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        hold_req   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready    = 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    // offer one transaction and return at the falling edge after it is taken
    task automatic send_item(input bbd_in_t item, input logic typed,
                             input logic [2:0] count, input logic [0:3][7:0] bytes);
        int unsigned gap;
        int unsigned target;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_data    = item;
        row_typed = typed;
        row_count = count;
        row_bytes = bytes;
        target    = inputs_taken + 1;
        while (inputs_taken != target) @(negedge aclk);
    endtask

    // sender pauses until every awaited result has come out
    task automatic wait_results_drained();
        s_valid = 1'b0;
        while (pending_bytes.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom);
        // mostly a proper continuation, now and then any byte
        if ($urandom_range(0, 15) != 0) r[7:6] = 2'b10;
        return r;
    endfunction

    // one random piece of text: well-formed sequences, broken ones and noise
    task automatic send_text_piece();
        logic [7:0]  piece[$];
        logic [7:0]  r;
        bbd_in_t     item;
        bit          broken;
        int unsigned kind;
        int unsigned len;
        int unsigned keep;
        int          i;
        broken = 1'b0;
        kind   = $urandom_range(0, 99);
        r      = 8'($urandom);
        if (kind < 30) begin
            r[7] = 1'b0;
            piece.insert(piece.size(), r);
        end else if (kind < 55) begin
            // two byte sequences with leads that can reach the alphabet
            piece.insert(piece.size(), 8'($urandom_range(PAIR_LEAD_LO, PAIR_LEAD_HI)));
            r[7:6] = 2'b10;
            piece.insert(piece.size(), r);
        end else if (kind < 65) begin
            piece.insert(piece.size(), {3'b110, r[4:0]});
            piece.insert(piece.size(), cont_byte());
        end else if (kind < 77) begin
            piece.insert(piece.size(), {4'b1110, r[3:0]});
            repeat (2) piece.insert(piece.size(), cont_byte());
        end else if (kind < 87) begin
            piece.insert(piece.size(), {5'b11110, r[2:0]});
            repeat (3) piece.insert(piece.size(), cont_byte());
        end else if (kind < 94) begin
            // lead followed by too few bytes
            broken = 1'b1;
            len    = $urandom_range(2, 4);
            case (len)
                2:       piece.insert(piece.size(), {3'b110, r[4:0]});
                3:       piece.insert(piece.size(), {4'b1110, r[3:0]});
                default: piece.insert(piece.size(), {5'b11110, r[2:0]});
            endcase
            keep = $urandom_range(0, len - 2);
            repeat (keep) piece.insert(piece.size(), cont_byte());
        end else begin
            piece.insert(piece.size(), r);
        end
        for (i = 0; i < piece.size(); i++) begin
            item.in_byte = piece[i];
            if (i == piece.size() - 1) begin
                item.end_of_text = broken ? 1'($urandom_range(0, 1))
                                          : ($urandom_range(0, 9) == 0);
            end else begin
                item.end_of_text = ($urandom_range(0, 29) == 0);
            end
            // dropped leads at an empty decoder do not count
            if (!(open_cnt == 0 && seq_len_of(item.in_byte) == 0)) random_items++;
            send_item(item, 1'b0, 3'd0, '0);
        end
    endtask

    initial begin
        bbd_in_t item;
        bit      held_once;
        bit      drained_once;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        row_typed    = 1'b0;
        row_count    = '0;
        row_bytes    = '0;
        open_seq     = '0;
        open_cnt     = 0;
        open_len     = 0;
        inputs_taken = 0;
        random_items = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        calm         = 1'b0;
        held_once    = 1'b0;
        drained_once = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            item.in_byte     = DIRECTED_ROWS[i].in_byte;
            item.end_of_text = DIRECTED_ROWS[i].eot;
            send_item(item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].count,
                      DIRECTED_ROWS[i].bytes);
        end

        // random text with calm stretches, one long hold-off and one full drain
        while (random_items < RANDOM_ITEMS) begin
            calm = ((random_items / 16) % 4 == 3);
            if (!held_once && random_items >= 100) begin
                held_once = 1'b1;
                calm      = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drained_once && random_items >= 230) begin
                drained_once = 1'b1;
                wait_results_drained();
            end
            send_text_piece();
        end

        wait_results_drained();
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0) begin
            $display("byte_level_unicode_to_byte_decoder test passed");
        end else begin
            $display("byte_level_unicode_to_byte_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bbd_pkg.sv
src/bbd_front.sv
src/bbd_queue.sv
src/bbd_back.sv
src/byte_level_unicode_to_byte_decoder.sv
tb/byte_level_unicode_to_byte_decoder_tb.sv
